// ----- design/pfe_pkg.sv -----
package pfe_pkg;

  // Expression bytes (ASCII)
  localparam logic [7:0] SYM_SPACE   = 8'h20;
  localparam logic [7:0] SYM_PERCENT = 8'h25;
  localparam logic [7:0] SYM_LPAREN  = 8'h28;
  localparam logic [7:0] SYM_RPAREN  = 8'h29;
  localparam logic [7:0] SYM_STAR    = 8'h2A;
  localparam logic [7:0] SYM_PLUS    = 8'h2B;
  localparam logic [7:0] SYM_MINUS   = 8'h2D;
  localparam logic [7:0] SYM_SLASH   = 8'h2F;
  localparam logic [7:0] SYM_ZERO    = 8'h30;

  // Value returned by a pop from an empty stack (-444)
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FE44;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_REPLACE
  } stk_op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_UP
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP2,
    ST_CALC,
    ST_DIV
  } pfe_state_e;

  typedef struct packed {
    logic start;
    logic want_rem;
  } div_req_t;

endpackage

// ----- design/pfe_cell.sv -----
module pfe_cell (
  input  logic              clk_i,
  input  pfe_pkg::cell_op_e op_i,
  input  logic [31:0]       upper_i,
  input  logic [31:0]       lower_i,
  output logic [31:0]       value_o
);
  import pfe_pkg::*;

  logic [31:0] value_q;
  logic [31:0] value_d;

  always_comb begin
    case (op_i)
      CELL_SHIFT_IN: value_d = upper_i;
      CELL_SHIFT_UP: value_d = lower_i;
      default:       value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- design/pfe_stack.sv -----
module pfe_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk_i,
  input  pfe_pkg::stk_op_e op_i,
  input  logic [31:0]      push_data_i,
  output logic [31:0]      top_o,
  output logic [31:0]      next_o
);
  import pfe_pkg::*;

  logic [31:0] val [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [31:0] upper;
    logic [31:0] lower;
    cell_op_e    op;

    if (i == 0) begin : g_first
      assign upper = push_data_i;
    end else begin : g_inner_up
      assign upper = val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign lower = val[i];
    end else begin : g_inner_down
      assign lower = val[i+1];
    end

    // Replace touches the top cell only
    always_comb begin
      case (op_i)
        STK_PUSH:    op = CELL_SHIFT_IN;
        STK_POP:     op = CELL_SHIFT_UP;
        STK_REPLACE: op = (i == 0) ? CELL_SHIFT_IN : CELL_HOLD;
        default:     op = CELL_HOLD;
      endcase
    end

    pfe_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .upper_i (upper),
      .lower_i (lower),
      .value_o (val[i])
    );
  end

  assign top_o  = val[0];
  assign next_o = val[1];

endmodule

// ----- design/pfe_div.sv -----
module pfe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_pkg::div_req_t req_i,
  input  logic [31:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  output logic [31:0]       result_o,
  output logic              done_o
);
  import pfe_pkg::*;

  logic        busy_q, fin_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dsr_q, result_q;
  logic        neg_q, want_rem_q;

  logic [32:0] shifted;
  logic [32:0] trial;
  logic [31:0] mag;

  // One quotient bit a cycle, restoring form
  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign mag     = want_rem_q ? rem_q : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q      <= '0;
      quo_q      <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dsr_q      <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      want_rem_q <= req_i.want_rem;
      neg_q      <= req_i.want_rem ? dividend_i[31] : (dividend_i[31] ^ divisor_i[31]);
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (fin_q) begin
      result_q <= neg_q ? (32'd0 - mag) : mag;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q)
    else $error("divider started while busy");

  a_fin_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) && !$past(req_i.start) |-> fin_q)
    else $error("divider ended without finishing");

  a_done_follows_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> done_o)
    else $error("divider result not flagged");
`endif

endmodule

// ----- design/postfix_expression_evaluator_top.sv -----
// Postfix expression evaluator. Feed one expression byte per item on symbol_i.
// Operand bytes push (byte - 48) onto a value stack of STACK_DEPTH entries; a push
// onto a full stack is dropped. The operators + - * / % pop the right operand, then
// the left one, and push the 32-bit wrapped result; ( and ) pop two values and push
// nothing. A pop from an empty stack gives -444 and sets the underflow flag.
// Division or modulo by zero gives 0 and sets the divide-by-zero flag. A space ends
// the expression: one result item carries the popped top (-444 with final_empty_o
// set if the stack was empty) and both flags, and the stack and flags clear.
// The stack is a row of 32-bit cells that shift as one: push moves every entry one
// cell down, pop one cell up, so the top two values always sit in fixed cells.
// Per item: operands and space finish on acceptance; ( and ) take one pop step per
// value popped; + - * pop, then write back; / and % with a non-zero divisor go
// through operand load, the 32-step bit-serial divider, sign fix-up and write-back.
// A result waits in an output register; input items keep flowing while it is
// taken, but every input item is stalled while out_stall_i holds that register.

module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         symbol_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               final_empty_o,
  output logic               underflow_seen_o,
  output logic               divide_by_zero_seen_o
);
  import pfe_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  // Sequencer state and stack bookkeeping
  pfe_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             uf_q, uf_d;
  logic             dz_q, dz_d;

  // Operands held across the execute cycles
  logic [31:0]      opr_q, opr_d;
  logic [31:0]      opl_q, opl_d;
  logic [7:0]       sym_q, sym_d;
  logic             two_q, two_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [31:0]      out_value_q;
  logic             out_empty_q, out_uf_q, out_dz_q;

  // Stack and divider hooks
  stk_op_e          stk_op;
  logic [31:0]      push_data;
  logic [31:0]      stk_top, stk_next;
  div_req_t         div_req;
  logic [31:0]      div_result;
  logic             div_done;

  logic             in_accept;
  logic             sym_op, sym_paren;
  logic             wb_en;
  logic [31:0]      wb_value;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sym_paren = symbol_i inside {SYM_LPAREN, SYM_RPAREN};
  assign sym_op    = sym_paren ||
                     (symbol_i inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_PERCENT});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    uf_d        = uf_q;
    dz_d        = dz_q;
    opr_d       = opr_q;
    opl_d       = opl_q;
    sym_d       = sym_q;
    two_d       = two_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    stk_op      = STK_HOLD;
    push_data   = '0;
    div_req     = '0;
    wb_en       = 1'b0;
    wb_value    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (symbol_i == SYM_SPACE) begin
            // End of expression: emit the top and flags, then wipe
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            cnt_d       = '0;
            uf_d        = 1'b0;
            dz_d        = 1'b0;
          end else if (sym_op) begin
            // Take right then left; an empty slot reads as the empty code
            opr_d = (cnt_q != '0) ? stk_top : EMPTY_VALUE;
            opl_d = (cnt_q >= CntW'(2)) ? stk_next : EMPTY_VALUE;
            sym_d = symbol_i;
            two_d = (cnt_q >= CntW'(2));
            if (cnt_q < CntW'(2)) begin
              uf_d = 1'b1;
            end
            if (cnt_q != '0) begin
              stk_op = STK_POP;
            end
            cnt_d = (cnt_q >= CntW'(2)) ? (cnt_q - CntW'(2)) : '0;
            if (sym_paren) begin
              state_d = (cnt_q >= CntW'(2)) ? ST_POP2 : ST_IDLE;
            end else begin
              state_d = ST_CALC;
            end
          end else if (cnt_q < CntW'(STACK_DEPTH)) begin
            // Operand byte: push it, drop it when full
            stk_op    = STK_PUSH;
            push_data = {24'd0, symbol_i} - {24'd0, SYM_ZERO};
            cnt_d     = cnt_q + CntW'(1);
          end
        end
      end

      ST_POP2: begin
        // Second pop of a parenthesis
        stk_op  = STK_POP;
        state_d = ST_IDLE;
      end

      ST_CALC: begin
        case (sym_q)
          SYM_PLUS: begin
            wb_en    = 1'b1;
            wb_value = opl_q + opr_q;
          end
          SYM_MINUS: begin
            wb_en    = 1'b1;
            wb_value = opl_q - opr_q;
          end
          SYM_STAR: begin
            wb_en    = 1'b1;
            wb_value = opl_q * opr_q;
          end
          SYM_SLASH, SYM_PERCENT: begin
            if (opr_q == '0) begin
              wb_en    = 1'b1;
              wb_value = '0;
              dz_d     = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.want_rem = (sym_q == SYM_PERCENT);
              state_d          = ST_DIV;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_DIV: begin
        if (div_done) begin
          wb_en    = 1'b1;
          wb_value = div_result;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Write back: the left operand's cell is overwritten when both pops hit
    if (wb_en) begin
      stk_op    = two_q ? STK_REPLACE : STK_PUSH;
      push_data = wb_value;
      cnt_d     = cnt_q + CntW'(1);
      state_d   = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      uf_q        <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      uf_q        <= uf_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    opr_q <= opr_d;
    opl_q <= opl_d;
    sym_q <= sym_d;
    two_q <= two_d;
    if (out_load) begin
      out_value_q <= (cnt_q != '0) ? stk_top : EMPTY_VALUE;
      out_empty_q <= (cnt_q == '0);
      out_uf_q    <= uf_q;
      out_dz_q    <= dz_q;
    end
  end

  pfe_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .op_i        (stk_op),
    .push_data_i (push_data),
    .top_o       (stk_top),
    .next_o      (stk_next)
  );

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (opl_q),
    .divisor_i  (opr_q),
    .result_o   (div_result),
    .done_o     (div_done)
  );

  assign out_valid_o           = out_valid_q;
  assign value_o               = out_value_q;
  assign final_empty_o         = out_empty_q;
  assign underflow_seen_o      = out_uf_q;
  assign divide_by_zero_seen_o = out_dz_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_space_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (symbol_i == SYM_SPACE) |=> (cnt_q == '0) && !uf_q && !dz_q && out_valid_q)
    else $error("end of expression did not clear state");

  a_div_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && div_done |=> (state_q == ST_IDLE))
    else $error("divide result not written back");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_op == STK_PUSH) |=> (cnt_q == $past(cnt_d)) && (cnt_q != '0))
    else $error("push left stack count wrong");
`endif

endmodule
